// File: rtl/ddsg_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ddsg_pkg
// Shared types, widths and constants of the differential drive safety
// governor: payload structs, configuration map, mode codes.
// ----------------------------------------------------------------------------
package ddsg_pkg;

    // Track values are Q2.TRACK_FRAC_BITS, full speed is TRACK_ONE
    localparam int TRACK_FRAC_BITS = 14;
    localparam int TRACK_ONE       = 1 << TRACK_FRAC_BITS;

    // Field widths
    localparam int Q_W        = 16;
    localparam int DIST_W     = 10;
    localparam int TILT_W     = 15;
    localparam int GAIN_W     = 16;
    localparam int SLEW_W     = 18;
    localparam int DEAD_W     = 15;
    localparam int ACC_W      = 16;
    localparam int TIME_W     = 18;
    localparam int PULSE_W    = 11;
    localparam int MODE_W     = 3;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 18;

    // Shared multiplier and divider sizes
    localparam int MUL_W   = 19;
    localparam int PROD_W  = 2 * MUL_W;
    localparam int DIV_N_W = 26;
    localparam int DIV_D_W = DIST_W;

    // Scaling constants
    localparam int YAW_SHIFT       = 12;
    localparam int YAW_D_W         = ACC_W + GAIN_W + 1 - YAW_SHIFT;
    localparam int SLEW_SHIFT      = 20;
    localparam int PULSE_CENTER    = 1500;
    localparam int PULSE_SCALE     = 400;
    localparam int ELAPSED_MAX     = 250000;
    localparam int ELAPSED_DEFAULT = 10000;

    // Register reset values
    localparam int RST_STOP_DIST  = 40;
    localparam int RST_SLOW_DIST  = 80;
    localparam int RST_TILT_LIMIT = 13107;
    localparam int RST_YAW_GAIN   = 6147;
    localparam int RST_SLEW_RATE  = 30924;
    localparam int RST_DEADBAND   = 819;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_STOP_DIST  = 3'd0,
        CFG_SLOW_DIST  = 3'd1,
        CFG_TILT_LIMIT = 3'd2,
        CFG_YAW_GAIN   = 3'd3,
        CFG_SLEW_RATE  = 3'd4,
        CFG_DEADBAND   = 3'd5,
        CFG_TILT_EN    = 3'd6,
        CFG_YAW_EN     = 3'd7
    } cfg_idx_t;

    typedef enum logic [MODE_W-1:0] {
        MODE_IDLE     = 3'd0,
        MODE_DRIVE    = 3'd1,
        MODE_OBSTACLE = 3'd2,
        MODE_TIMEOUT  = 3'd3,
        MODE_TILT     = 3'd4
    } mode_t;

    typedef struct packed {
        logic [DIST_W-1:0] stop_distance_cm;
        logic [DIST_W-1:0] slow_distance_cm;
        logic [TILT_W-1:0] tilt_limit_raw;
        logic [GAIN_W-1:0] yaw_gain;
        logic [SLEW_W-1:0] slew_rate;
        logic [DEAD_W-1:0] idle_deadband;
        logic              tilt_enable;
        logic              yaw_damp_enable;
    } cfg_t;

    typedef struct packed {
        logic signed [Q_W-1:0]   host_left;
        logic signed [Q_W-1:0]   host_right;
        logic                    host_timeout;
        logic                    lidar_valid;
        logic [DIST_W-1:0]       lidar_cm;
        logic                    motion_fresh;
        logic signed [ACC_W-1:0] accel_x;
        logic signed [ACC_W-1:0] accel_y;
        logic signed [ACC_W-1:0] gyro_z;
        logic [TIME_W-1:0]       elapsed_us;
    } in_item_t;

    typedef struct packed {
        logic signed [Q_W-1:0] left_drive;
        logic signed [Q_W-1:0] right_drive;
        logic [PULSE_W-1:0]    left_pulse_us;
        logic [PULSE_W-1:0]    right_pulse_us;
        logic [MODE_W-1:0]     mode;
    } out_item_t;

endpackage

// File: rtl/ddsg_cfg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ddsg_cfg
// Configuration register file: one write per cycle by index, reset to the
// documented defaults.
// ----------------------------------------------------------------------------
module ddsg_cfg
    import ddsg_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  we,
    input  logic [CFG_IDX_W-1:0]  index,
    input  logic [CFG_DATA_W-1:0] wdata,
    output cfg_t                  regs
);

    cfg_t cfg_reg;

    // Write the addressed register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.stop_distance_cm <= DIST_W'(RST_STOP_DIST);
            cfg_reg.slow_distance_cm <= DIST_W'(RST_SLOW_DIST);
            cfg_reg.tilt_limit_raw   <= TILT_W'(RST_TILT_LIMIT);
            cfg_reg.yaw_gain         <= GAIN_W'(RST_YAW_GAIN);
            cfg_reg.slew_rate        <= SLEW_W'(RST_SLEW_RATE);
            cfg_reg.idle_deadband    <= DEAD_W'(RST_DEADBAND);
            cfg_reg.tilt_enable      <= 1'b1;
            cfg_reg.yaw_damp_enable  <= 1'b1;
        end
        else if (we)
        begin
            unique case (cfg_idx_t'(index))
                CFG_STOP_DIST:  cfg_reg.stop_distance_cm <= wdata[DIST_W-1:0];
                CFG_SLOW_DIST:  cfg_reg.slow_distance_cm <= wdata[DIST_W-1:0];
                CFG_TILT_LIMIT: cfg_reg.tilt_limit_raw   <= wdata[TILT_W-1:0];
                CFG_YAW_GAIN:   cfg_reg.yaw_gain         <= wdata[GAIN_W-1:0];
                CFG_SLEW_RATE:  cfg_reg.slew_rate        <= wdata[SLEW_W-1:0];
                CFG_DEADBAND:   cfg_reg.idle_deadband    <= wdata[DEAD_W-1:0];
                CFG_TILT_EN:    cfg_reg.tilt_enable      <= wdata[0];
                CFG_YAW_EN:     cfg_reg.yaw_damp_enable  <= wdata[0];
                default:        ;
            endcase
        end
    end

    assign regs = cfg_reg;

endmodule

// File: rtl/ddsg_mul.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ddsg_mul
// Shared signed multiplier with a registered product; the sequencer steers
// its operands, and the product is read in the following cycle.
// ----------------------------------------------------------------------------
module ddsg_mul
    import ddsg_pkg::*;
#(
    parameter int W = MUL_W
)
(
    input  logic                  clk,
    input  logic signed [W-1:0]   a,
    input  logic signed [W-1:0]   b,
    output logic signed [2*W-1:0] prod
);

    logic signed [2*W-1:0] prod_reg;

    // Register every product
    always_ff @(posedge clk)
    begin
        prod_reg <= (2*W)'(a) * (2*W)'(b);
    end

    assign prod = prod_reg;

endmodule

// File: rtl/ddsg_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ddsg_div
// Restoring unsigned divider, one quotient bit per cycle. A start pulse
// loads the operands; done pulses for one cycle with the quotient final.
// ----------------------------------------------------------------------------
module ddsg_div
    import ddsg_pkg::*;
#(
    parameter int N_W = DIV_N_W,
    parameter int D_W = DIV_D_W
)
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           start,
    input  logic [N_W-1:0] dividend,
    input  logic [D_W-1:0] divisor,
    output logic           done,
    output logic [N_W-1:0] quotient
);

    localparam int CNT_W = $clog2(N_W + 1);

    logic [D_W:0]   rem_reg;
    logic [N_W-1:0] quo_reg;
    logic [D_W-1:0] den_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic           busy_reg;
    logic           done_reg;

    logic [D_W:0]   trial;
    logic           fits;

    // Shift in the next dividend bit and try the subtract
    always_comb
    begin
        trial = {rem_reg[D_W-1:0], quo_reg[N_W-1]};
        fits  = (trial >= {1'b0, den_reg});
    end

    // Load on start, then iterate one bit per cycle
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rem_reg  <= '0;
            quo_reg  <= '0;
            den_reg  <= '0;
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                rem_reg  <= '0;
                quo_reg  <= dividend;
                den_reg  <= divisor;
                cnt_reg  <= CNT_W'(N_W);
                busy_reg <= 1'b1;
            end
            else if (busy_reg)
            begin
                rem_reg <= fits ? (trial - {1'b0, den_reg}) : trial;
                quo_reg <= {quo_reg[N_W-2:0], fits};
                cnt_reg <= cnt_reg - CNT_W'(1);
                if (cnt_reg == CNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

// File: rtl/differential_drive_safety_governor.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// differential_drive_safety_governor
// Per-tick safety chain for two track commands: timeout, lidar stop and
// slow-down, tilt stop, yaw damping, slew limiting, pulse widths and mode.
// ----------------------------------------------------------------------------
// One transaction is worked on at a time. After acceptance the result is
// registered through the prepare, tilt, yaw, slew, left pulse, right pulse
// and done states; a lidar reading in the slow band adds a recombine state,
// and when the forward part is positive also a multiply and the
// one-bit-per-cycle divider that scales it. A new transaction can be taken
// in the cycle after the result is loaded. All products (forward scaling,
// yaw damping, slew step, pulse widths) share one registered 19x19
// multiplier in turn. The result register lets the next transaction start
// while the last result waits on out_ready. Configuration writes land at
// once and must only be made between ticks.
// ----------------------------------------------------------------------------
module differential_drive_safety_governor
    import ddsg_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  in_item_t              in_data,
    output logic                  out_valid,
    input  logic                  out_ready,
    output out_item_t             out_data
);

    localparam int SUM_W = 22;
    localparam int DF_W  = Q_W + 2;

    typedef enum logic [3:0] {
        S_IDLE,
        S_PREP,
        S_SMUL,
        S_DSTART,
        S_DWAIT,
        S_RECOMB,
        S_TILT,
        S_YAW,
        S_SLEW,
        S_PL,
        S_PR,
        S_DONE
    } state_t;

    // Saturate to plus or minus one
    function automatic logic signed [Q_W-1:0] clamp_q(input logic signed [SUM_W-1:0] x);
        logic signed [SUM_W-1:0] one_s;
        one_s = SUM_W'(TRACK_ONE);
        if (x > one_s)
            return Q_W'(one_s);
        else if (x < -one_s)
            return Q_W'(-one_s);
        else
            return Q_W'(x);
    endfunction

    // Halve, rounding toward zero
    function automatic logic signed [DF_W-1:0] half_tz(input logic signed [DF_W-1:0] x);
        logic signed [DF_W-1:0] r;
        r = x + ((x < 0) ? DF_W'(1) : DF_W'(0));
        return r >>> 1;
    endfunction

    // Move a level toward its target by at most step
    function automatic logic signed [Q_W-1:0] slew_q(input logic signed [Q_W-1:0] cur,
                                                    input logic signed [Q_W-1:0] tgt,
                                                    input logic [Q_W-1:0] step);
        logic signed [DF_W-1:0] cur_s;
        logic signed [DF_W-1:0] tgt_s;
        logic signed [DF_W-1:0] step_s;
        logic signed [DF_W-1:0] hi;
        logic signed [DF_W-1:0] lo;
        cur_s  = DF_W'(cur);
        tgt_s  = DF_W'(tgt);
        step_s = DF_W'(step);
        hi     = cur_s + step_s;
        lo     = cur_s - step_s;
        if (tgt_s > hi)
            return Q_W'(hi);
        else if (tgt_s < lo)
            return Q_W'(lo);
        else
            return tgt;
    endfunction

    // Pulse width from level times scale, truncated toward zero
    function automatic logic [PULSE_W-1:0] pulse_us(input logic signed [PROD_W-1:0] p);
        logic signed [PROD_W-1:0] adj;
        logic signed [PROD_W-1:0] q;
        adj = p + ((p < 0) ? PROD_W'(TRACK_ONE - 1) : PROD_W'(0));
        q   = adj >>> TRACK_FRAC_BITS;
        return PULSE_W'(PULSE_CENTER) + q[PULSE_W-1:0];
    endfunction

    // Magnitude of a level
    function automatic logic [Q_W-1:0] mag_q(input logic signed [Q_W-1:0] x);
        return (x < 0) ? Q_W'(-x) : Q_W'(x);
    endfunction

    cfg_t cfg;

    state_t    state_reg;
    in_item_t  item_reg;
    logic signed [Q_W-1:0] tl_reg;
    logic signed [Q_W-1:0] tr_reg;
    logic signed [Q_W:0]   f2_reg;
    logic signed [Q_W:0]   t2_reg;
    logic [TIME_W-1:0]     el_reg;
    logic                  tilt_reg;
    logic                  obst_reg;
    logic signed [Q_W-1:0] left_level_reg;
    logic signed [Q_W-1:0] right_level_reg;
    logic [PULSE_W-1:0]    left_pulse_reg;
    logic                  out_valid_reg;
    out_item_t             out_data_reg;

    logic signed [MUL_W-1:0]  mul_a;
    logic signed [MUL_W-1:0]  mul_b;
    logic signed [PROD_W-1:0] prod;
    logic                     div_start;
    logic                     div_done;
    logic [DIV_N_W-1:0]       quotient;

    logic signed [Q_W-1:0]   tl_c;
    logic signed [Q_W-1:0]   tr_c;
    logic signed [Q_W:0]     f2_c;
    logic signed [Q_W:0]     t2_c;
    logic [DIST_W-1:0]       num_c;
    logic [DIST_W-1:0]       den_c;
    logic                    near_c;
    logic                    band_c;
    logic signed [ACC_W:0]   ax_ext;
    logic signed [ACC_W:0]   ay_ext;
    logic [ACC_W:0]          ax_mag;
    logic [ACC_W:0]          ay_mag;
    logic                    tilt_c;
    logic [TIME_W-1:0]       el_c;
    logic signed [YAW_D_W-1:0] damp_c;
    logic                    damp_en_c;
    logic [Q_W-1:0]          step_c;
    logic                    driving_c;
    logic                    out_free;

    ddsg_cfg u_cfg (
        .clk   (clk),
        .rst_n (rst_n),
        .we    (cfg_we),
        .index (cfg_index),
        .wdata (cfg_wdata),
        .regs  (cfg)
    );

    ddsg_mul #(
        .W (MUL_W)
    ) u_mul (
        .clk  (clk),
        .a    (mul_a),
        .b    (mul_b),
        .prod (prod)
    );

    ddsg_div #(
        .N_W (DIV_N_W),
        .D_W (DIV_D_W)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (prod[DIV_N_W-1:0]),
        .divisor  (den_c),
        .done     (div_done),
        .quotient (quotient)
    );

    // Decode the held transaction: clamped commands, lidar bands, tilt, time
    always_comb
    begin
        tl_c   = item_reg.host_timeout ? '0 : clamp_q(SUM_W'(item_reg.host_left));
        tr_c   = item_reg.host_timeout ? '0 : clamp_q(SUM_W'(item_reg.host_right));
        f2_c   = (Q_W+1)'(tl_c) + (Q_W+1)'(tr_c);
        t2_c   = (Q_W+1)'(tr_c) - (Q_W+1)'(tl_c);
        num_c  = item_reg.lidar_cm - cfg.stop_distance_cm;
        den_c  = cfg.slow_distance_cm - cfg.stop_distance_cm;
        near_c = item_reg.lidar_valid && (item_reg.lidar_cm <= cfg.stop_distance_cm);
        band_c = item_reg.lidar_valid && (item_reg.lidar_cm > cfg.stop_distance_cm)
                 && (item_reg.lidar_cm < cfg.slow_distance_cm);
        ax_ext = (ACC_W+1)'(item_reg.accel_x);
        ay_ext = (ACC_W+1)'(item_reg.accel_y);
        ax_mag = (ax_ext < 0) ? (ACC_W+1)'(-ax_ext) : (ACC_W+1)'(ax_ext);
        ay_mag = (ay_ext < 0) ? (ACC_W+1)'(-ay_ext) : (ACC_W+1)'(ay_ext);
        tilt_c = cfg.tilt_enable && item_reg.motion_fresh
                 && ((ax_mag > (ACC_W+1)'(cfg.tilt_limit_raw))
                 || (ay_mag > (ACC_W+1)'(cfg.tilt_limit_raw)));
        el_c   = ((item_reg.elapsed_us == '0)
                 || (item_reg.elapsed_us > TIME_W'(ELAPSED_MAX)))
                 ? TIME_W'(ELAPSED_DEFAULT) : item_reg.elapsed_us;
    end

    // Pick apart the shared product and the result conditions
    always_comb
    begin
        damp_c    = prod[YAW_SHIFT+YAW_D_W-1:YAW_SHIFT];
        damp_en_c = cfg.yaw_damp_enable && item_reg.motion_fresh && !tilt_reg;
        step_c    = prod[SLEW_SHIFT+Q_W-1:SLEW_SHIFT];
        driving_c = (mag_q(left_level_reg) > Q_W'(cfg.idle_deadband))
                    || (mag_q(right_level_reg) > Q_W'(cfg.idle_deadband));
        out_free  = !out_valid_reg || out_ready;
        div_start = (state_reg == S_DSTART);
    end

    // Steer the shared multiplier
    always_comb
    begin
        unique case (state_reg)
            S_SMUL:
            begin
                mul_a = MUL_W'(f2_reg);
                mul_b = MUL_W'(num_c);
            end
            S_TILT:
            begin
                mul_a = MUL_W'(item_reg.gyro_z);
                mul_b = MUL_W'(cfg.yaw_gain);
            end
            S_YAW:
            begin
                mul_a = MUL_W'(cfg.slew_rate);
                mul_b = MUL_W'(el_reg);
            end
            S_PL:
            begin
                mul_a = MUL_W'(left_level_reg);
                mul_b = MUL_W'(PULSE_SCALE);
            end
            S_PR, S_DONE:
            begin
                mul_a = MUL_W'(right_level_reg);
                mul_b = MUL_W'(PULSE_SCALE);
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // Sequence one transaction through the safety chain
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            item_reg        <= '0;
            tl_reg          <= '0;
            tr_reg          <= '0;
            f2_reg          <= '0;
            t2_reg          <= '0;
            el_reg          <= '0;
            tilt_reg        <= 1'b0;
            obst_reg        <= 1'b0;
            left_level_reg  <= '0;
            right_level_reg <= '0;
            left_pulse_reg  <= '0;
            out_valid_reg   <= 1'b0;
            out_data_reg    <= '0;
        end
        else
        begin
            // Raise the result on completion, drop it once taken
            if ((state_reg == S_DONE) && out_free)
                out_valid_reg <= 1'b1;
            else if (out_valid_reg && out_ready)
                out_valid_reg <= 1'b0;

            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_valid)
                    begin
                        item_reg  <= in_data;
                        state_reg <= S_PREP;
                    end
                end
                S_PREP:
                begin
                    // Zero both targets in the stop zone
                    tl_reg   <= near_c ? '0 : tl_c;
                    tr_reg   <= near_c ? '0 : tr_c;
                    f2_reg   <= f2_c;
                    t2_reg   <= t2_c;
                    el_reg   <= el_c;
                    tilt_reg <= tilt_c;
                    obst_reg <= near_c || band_c;
                    if (band_c)
                        state_reg <= (f2_c > 0) ? S_SMUL : S_RECOMB;
                    else
                        state_reg <= S_TILT;
                end
                S_SMUL:
                    state_reg <= S_DSTART;
                S_DSTART:
                    state_reg <= S_DWAIT;
                S_DWAIT:
                begin
                    if (div_done)
                    begin
                        f2_reg    <= signed'({1'b0, quotient[Q_W-1:0]});
                        state_reg <= S_RECOMB;
                    end
                end
                S_RECOMB:
                begin
                    tl_reg    <= clamp_q(SUM_W'(half_tz(DF_W'(f2_reg) - DF_W'(t2_reg))));
                    tr_reg    <= clamp_q(SUM_W'(half_tz(DF_W'(f2_reg) + DF_W'(t2_reg))));
                    state_reg <= S_TILT;
                end
                S_TILT:
                begin
                    if (tilt_reg)
                    begin
                        tl_reg <= '0;
                        tr_reg <= '0;
                    end
                    state_reg <= S_YAW;
                end
                S_YAW:
                begin
                    if (damp_en_c)
                    begin
                        tl_reg <= clamp_q(SUM_W'(tl_reg) + SUM_W'(damp_c));
                        tr_reg <= clamp_q(SUM_W'(tr_reg) - SUM_W'(damp_c));
                    end
                    state_reg <= S_SLEW;
                end
                S_SLEW:
                begin
                    left_level_reg  <= slew_q(left_level_reg, tl_reg, step_c);
                    right_level_reg <= slew_q(right_level_reg, tr_reg, step_c);
                    state_reg       <= S_PL;
                end
                S_PL:
                    state_reg <= S_PR;
                S_PR:
                begin
                    left_pulse_reg <= pulse_us(prod);
                    state_reg      <= S_DONE;
                end
                S_DONE:
                begin
                    // Hold until the result register is free
                    if (out_free)
                    begin
                        out_data_reg.left_drive     <= left_level_reg;
                        out_data_reg.right_drive    <= right_level_reg;
                        out_data_reg.left_pulse_us  <= left_pulse_reg;
                        out_data_reg.right_pulse_us <= pulse_us(prod);
                        if (tilt_reg)
                            out_data_reg.mode <= MODE_TILT;
                        else if (item_reg.host_timeout)
                            out_data_reg.mode <= MODE_TIMEOUT;
                        else if (obst_reg)
                            out_data_reg.mode <= MODE_OBSTACLE;
                        else if (driving_c)
                            out_data_reg.mode <= MODE_DRIVE;
                        else
                            out_data_reg.mode <= MODE_IDLE;
                        state_reg <= S_IDLE;
                    end
                end
                default:
                    state_reg <= S_IDLE;
            endcase
        end
    end

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule
